/* hw/rtl/lrf_pkg.sv */
// Shared types, register indexes and effect codes of the LED ripple/fade/pulse block.
// Holds the distance function used to build the elaboration-time distance table.
// No dependencies.
package lrf_pkg;

  // Effect codes carried in the input word.
  localparam logic [1:0] EFF_RIPPLE = 2'd0;
  localparam logic [1:0] EFF_FADE   = 2'd1;
  localparam logic [1:0] EFF_PULSE  = 2'd2;
  localparam logic [1:0] EFF_NONE   = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_RIPPLE_DUR = 3'd0;
  localparam logic [2:0] REG_FADE_DUR   = 3'd1;
  localparam logic [2:0] REG_RISE       = 3'd2;
  localparam logic [2:0] REG_HOLD       = 3'd3;
  localparam logic [2:0] REG_FALL       = 3'd4;
  localparam logic [2:0] REG_STEADY     = 3'd5;
  localparam logic [2:0] REG_MAX_RADIUS = 3'd6;

  // How the back end turns the quotient into a level.
  localparam logic [1:0] MODE_RIPPLE = 2'd0;
  localparam logic [1:0] MODE_QUOT   = 2'd1;
  localparam logic [1:0] MODE_FULL   = 2'd2;
  localparam logic [1:0] MODE_ZERO   = 2'd3;

  localparam int LVL_W   = 12;
  localparam int DUR_W   = 16;
  localparam int DIST_W  = 18;
  localparam int NUM_W   = 32;
  localparam logic [LVL_W-1:0] MAX_LEVEL = 12'hFFF;

  // Per-item control that travels beside the divider.
  typedef struct packed {
    logic [1:0]        mode;
    logic              green_en;
    logic [DIST_W-1:0] dist_q;
  } lrf_side_t;

  // Distance in Q6.12 for doubled offsets: floor(sqrt((dr2^2 + dc2^2) << 22)).
  // Only evaluated at elaboration.
  function automatic logic [DIST_W-1:0] isqrt_q12(input int dr2, input int dc2);
    longint v;
    longint r;
    longint b;
    v = longint'(dr2 * dr2 + dc2 * dc2) <<< 22;
    r = 0;
    b = longint'(1) <<< 46;
    for (int i = 0; i < 24; i++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >>> 1) + b;
        end else begin
          r = r >>> 1;
        end
        b = b >>> 2;
      end
    end
    return r[DIST_W-1:0];
  endfunction

endpackage

/* hw/rtl/lrf_front.sv */
// Front stage: decodes one input word into a dividend, a divisor and back-end control.
// Depends on lrf_pkg.
module lrf_front #(
  parameter int PAD_ROWS  = 4,
  parameter int FIRST_COL = 1,
  parameter int LAST_COL  = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            in_valid,
  input  logic [1:0]                      effect,
  input  logic [2:0]                      row,
  input  logic [2:0]                      col,
  input  logic                            is_underglow,
  input  logic [lrf_pkg::DUR_W-1:0]       elapsed,
  input  logic [lrf_pkg::DUR_W-1:0]       ripple_dur,
  input  logic [lrf_pkg::DUR_W-1:0]       fade_dur,
  input  logic [lrf_pkg::DUR_W-1:0]       rise,
  input  logic [lrf_pkg::DUR_W-1:0]       hold,
  input  logic [lrf_pkg::DUR_W-1:0]       fall,
  input  logic [lrf_pkg::LVL_W-1:0]       steady,
  input  logic [lrf_pkg::DUR_W-1:0]       max_radius,
  output logic                            out_valid,
  output logic [lrf_pkg::NUM_W-1:0]       out_num,
  output logic [lrf_pkg::DUR_W-1:0]       out_den,
  output lrf_pkg::lrf_side_t              out_side
);

  // Distance table over every row and column code, built at elaboration.
  logic [lrf_pkg::DIST_W-1:0] dist_tab [0:63];

  for (genvar r = 0; r < 8; r++) begin : g_row
    for (genvar c = 0; c < 8; c++) begin : g_col
      localparam int DR2 = 2 * r - 2 * PAD_ROWS;
      localparam int DC2 = 2 * c - (FIRST_COL + LAST_COL);
      assign dist_tab[r*8+c] = lrf_pkg::isqrt_q12(DR2, DC2);
    end
  end

  logic [lrf_pkg::DUR_W-1:0] rip_t;
  logic [lrf_pkg::DUR_W-1:0] fade_t;
  logic [lrf_pkg::DUR_W-1:0] past_rise;
  logic [lrf_pkg::DUR_W-1:0] past_hold;
  logic [lrf_pkg::DUR_W-1:0] mul_a;
  logic [lrf_pkg::DUR_W-1:0] mul_b;
  logic [lrf_pkg::DUR_W-1:0] den;
  logic [1:0]                mode;
  logic                      green_en;

  logic                        valid_r;
  logic [lrf_pkg::NUM_W-1:0]   num_r;
  logic [lrf_pkg::DUR_W-1:0]   den_r;
  lrf_pkg::lrf_side_t          side_r;
  logic [lrf_pkg::NUM_W-1:0]   num_nxt;
  lrf_pkg::lrf_side_t          side_nxt;

  assign rip_t     = (elapsed < ripple_dur) ? elapsed : ripple_dur;
  assign fade_t    = (elapsed < fade_dur) ? elapsed : fade_dur;
  assign past_rise = elapsed - rise;
  assign past_hold = past_rise - hold;

  // Pick the multiplier operands and divisor for the effect; one shared multiplier.
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    den      = lrf_pkg::DUR_W'(1);
    mode     = lrf_pkg::MODE_ZERO;
    green_en = 1'b1;
    case (effect)
      lrf_pkg::EFF_RIPPLE: begin
        if (!is_underglow) begin
          mode  = lrf_pkg::MODE_RIPPLE;
          mul_b = max_radius;
          if (ripple_dur == '0) begin
            mul_a = lrf_pkg::DUR_W'(1);
          end else begin
            mul_a = rip_t;
            den   = ripple_dur;
          end
        end
      end
      lrf_pkg::EFF_FADE: begin
        if (!is_underglow && fade_dur != '0) begin
          mode  = lrf_pkg::MODE_QUOT;
          mul_a = lrf_pkg::DUR_W'(steady);
          mul_b = fade_dur - fade_t;
          den   = fade_dur;
        end
      end
      lrf_pkg::EFF_PULSE: begin
        green_en = !is_underglow && (row == 3'd0);
        if (elapsed < rise) begin
          mode  = lrf_pkg::MODE_QUOT;
          mul_a = elapsed;
          mul_b = lrf_pkg::DUR_W'(4096);
          den   = rise;
        end else if (past_rise < hold) begin
          mode = lrf_pkg::MODE_FULL;
        end else if (past_hold < fall) begin
          mode  = lrf_pkg::MODE_QUOT;
          mul_a = fall - past_hold;
          mul_b = lrf_pkg::DUR_W'(4096);
          den   = fall;
        end
      end
      default: begin
        mode = lrf_pkg::MODE_ZERO;
      end
    endcase
  end

  assign num_nxt         = lrf_pkg::NUM_W'(mul_a) * lrf_pkg::NUM_W'(mul_b);
  assign side_nxt.mode     = mode;
  assign side_nxt.green_en = green_en;
  assign side_nxt.dist_q   = dist_tab[{row, col}];

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r  <= num_nxt;
      den_r  <= den;
      side_r <= side_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_num   = num_r;
  assign out_den   = den_r;
  assign out_side  = side_r;

endmodule

/* hw/rtl/lrf_div.sv */
// Pipelined restoring divider, one quotient bit per stage, control carried alongside.
// Needs dividend < divisor * 2^16. Depends on lrf_pkg.
module lrf_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [lrf_pkg::NUM_W-1:0] in_num,
  input  logic [lrf_pkg::DUR_W-1:0] in_den,
  input  lrf_pkg::lrf_side_t        in_side,
  output logic                      out_valid,
  output logic [lrf_pkg::DUR_W-1:0] out_quot,
  output lrf_pkg::lrf_side_t        out_side
);

  localparam int QW = lrf_pkg::DUR_W;

  logic              valid_r [0:QW-1];
  logic [QW-1:0]     rem_r   [0:QW-1];
  logic [QW-1:0]     low_r   [0:QW-1];
  logic [QW-1:0]     quot_r  [0:QW-1];
  logic [QW-1:0]     den_r   [0:QW-1];
  lrf_pkg::lrf_side_t side_r [0:QW-1];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic              src_valid;
    logic [QW-1:0]     src_rem;
    logic [QW-1:0]     src_low;
    logic [QW-1:0]     src_quot;
    logic [QW-1:0]     src_den;
    lrf_pkg::lrf_side_t src_side;
    logic [QW:0]       trial;
    logic              take;
    logic [QW-1:0]     rem_nxt;
    logic [QW-1:0]     quot_nxt;

    if (k == 0) begin : g_first
      assign src_valid = in_valid;
      assign src_rem   = in_num[lrf_pkg::NUM_W-1:QW];
      assign src_low   = in_num[QW-1:0];
      assign src_quot  = '0;
      assign src_den   = in_den;
      assign src_side  = in_side;
    end else begin : g_next
      assign src_valid = valid_r[k-1];
      assign src_rem   = rem_r[k-1];
      assign src_low   = low_r[k-1];
      assign src_quot  = quot_r[k-1];
      assign src_den   = den_r[k-1];
      assign src_side  = side_r[k-1];
    end

    // Shift in the next dividend bit and subtract when it fits.
    assign trial    = {src_rem, src_low[QW-1-k]};
    assign take     = trial >= {1'b0, src_den};
    assign rem_nxt  = take ? QW'(trial - {1'b0, src_den}) : trial[QW-1:0];
    assign quot_nxt = src_quot | (QW'(take) << (QW - 1 - k));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (adv) begin
        valid_r[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= rem_nxt;
        low_r[k]  <= src_low;
        quot_r[k] <= quot_nxt;
        den_r[k]  <= src_den;
        side_r[k] <= src_side;
      end
    end
  end

  assign out_valid = valid_r[QW-1];
  assign out_quot  = quot_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

/* hw/rtl/lrf_back.sv */
// Back stage: turns the quotient into channel levels and holds the output register.
// Depends on lrf_pkg.
module lrf_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [lrf_pkg::DUR_W-1:0] in_quot,
  input  lrf_pkg::lrf_side_t        in_side,
  input  logic [lrf_pkg::LVL_W-1:0] steady,
  output logic                      out_valid,
  output logic [lrf_pkg::LVL_W-1:0] red,
  output logic [lrf_pkg::LVL_W-1:0] green,
  output logic [lrf_pkg::LVL_W-1:0] blue
);

  logic signed [lrf_pkg::DIST_W:0]  edge_s;
  logic [12:0]                      edge_c;
  logic [24:0]                      prod;
  logic [lrf_pkg::LVL_W-1:0]        level;

  logic                        valid_r;
  logic [lrf_pkg::LVL_W-1:0]   rb_r;
  logic [lrf_pkg::LVL_W-1:0]   g_r;

  // Ripple front: radius minus distance, clamped to one full unit, times steady level.
  assign edge_s = $signed((lrf_pkg::DIST_W+1)'(in_quot))
                - $signed({1'b0, in_side.dist_q});
  assign edge_c = (edge_s < 0) ? 13'd0 :
                  (edge_s > $signed((lrf_pkg::DIST_W+1)'(4096))) ? 13'd4096 :
                  edge_s[12:0];
  assign prod   = 25'(edge_c) * 25'(steady);

  always_comb begin
    case (in_side.mode)
      lrf_pkg::MODE_RIPPLE: level = prod[23:12];
      lrf_pkg::MODE_QUOT:
        level = (in_quot > lrf_pkg::DUR_W'(lrf_pkg::MAX_LEVEL)) ?
                lrf_pkg::MAX_LEVEL : in_quot[lrf_pkg::LVL_W-1:0];
      lrf_pkg::MODE_FULL:   level = lrf_pkg::MAX_LEVEL;
      default:              level = '0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rb_r <= level;
      g_r  <= in_side.green_en ? level : '0;
    end
  end

  assign out_valid = valid_r;
  assign red       = rb_r;
  assign green     = g_r;
  assign blue      = rb_r;

endmodule

/* hw/rtl/led_ripple_fade_pulse_effect.sv */
// Top level of the LED ripple/fade/pulse level generator: config registers and pipeline.
// Depends on lrf_pkg, lrf_front, lrf_div and lrf_back.
//
//  channel  | direction | contents
//  in_      | slave     | tdata: row, col, elapsed; tuser: effect, is_underglow
//  out_     | master    | tdata: red, green, blue
//  cfg_     | write     | register index and data, taken when cfg_we is high
//
// One word enters per cycle while the output is not stalled; each result passes the front
// stage, 16 divider stages producing one quotient bit each, and the output stage.
// Reset (synchronous, rst_n low) empties the pipeline and loads the register defaults.
// A stall on the output holds every stage in place; in_tready falls with it.
module led_ripple_fade_pulse_effect #(
  parameter int PAD_ROWS  = 4,
  parameter int FIRST_COL = 1,
  parameter int LAST_COL  = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // row[2:0], col[5:3], elapsed[21:6], zero fill
  input  logic [2:0]  in_tuser,   // effect[1:0], is_underglow[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // red[11:0], green[23:12], blue[35:24], zero fill
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] ripple_dur_r;
  logic [15:0] fade_dur_r;
  logic [15:0] rise_r;
  logic [15:0] hold_r;
  logic [15:0] fall_r;
  logic [11:0] steady_r;
  logic [15:0] max_radius_r;

  logic                      adv;
  logic                      f_valid;
  logic [lrf_pkg::NUM_W-1:0] f_num;
  logic [15:0]               f_den;
  lrf_pkg::lrf_side_t        f_side;
  logic                      d_valid;
  logic [15:0]               d_quot;
  lrf_pkg::lrf_side_t        d_side;
  logic [11:0]               red;
  logic [11:0]               green;
  logic [11:0]               blue;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ripple_dur_r <= 16'd900;
      fade_dur_r   <= 16'd500;
      rise_r       <= 16'd150;
      hold_r       <= 16'd120;
      fall_r       <= 16'd350;
      steady_r     <= 12'd3686;
      max_radius_r <= 16'd18842;
    end else if (cfg_we) begin
      case (cfg_addr)
        lrf_pkg::REG_RIPPLE_DUR: ripple_dur_r <= cfg_wdata;
        lrf_pkg::REG_FADE_DUR:   fade_dur_r   <= cfg_wdata;
        lrf_pkg::REG_RISE:       rise_r       <= cfg_wdata;
        lrf_pkg::REG_HOLD:       hold_r       <= cfg_wdata;
        lrf_pkg::REG_FALL:       fall_r       <= cfg_wdata;
        lrf_pkg::REG_STEADY:     steady_r     <= cfg_wdata[11:0];
        lrf_pkg::REG_MAX_RADIUS: max_radius_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves when the output register is free or being drained.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  lrf_front #(
    .PAD_ROWS (PAD_ROWS),
    .FIRST_COL(FIRST_COL),
    .LAST_COL (LAST_COL)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (in_tvalid),
    .effect      (in_tuser[1:0]),
    .row         (in_tdata[2:0]),
    .col         (in_tdata[5:3]),
    .is_underglow(in_tuser[2]),
    .elapsed     (in_tdata[21:6]),
    .ripple_dur  (ripple_dur_r),
    .fade_dur    (fade_dur_r),
    .rise        (rise_r),
    .hold        (hold_r),
    .fall        (fall_r),
    .steady      (steady_r),
    .max_radius  (max_radius_r),
    .out_valid   (f_valid),
    .out_num     (f_num),
    .out_den     (f_den),
    .out_side    (f_side)
  );

  lrf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (f_valid),
    .in_num   (f_num),
    .in_den   (f_den),
    .in_side  (f_side),
    .out_valid(d_valid),
    .out_quot (d_quot),
    .out_side (d_side)
  );

  lrf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (d_valid),
    .in_quot  (d_quot),
    .in_side  (d_side),
    .steady   (steady_r),
    .out_valid(out_tvalid),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

  assign out_tdata = {4'd0, blue, green, red};

endmodule

/* tb/led_ripple_fade_pulse_effect_test.sv */
// Self-checking testbench of the LED ripple/fade/pulse level generator.
// Drives directed and random words with bursty input and output stalls and checks each
// output word against a predictor of its own. Depends on lrf_pkg and the top level.
`timescale 1ns / 100ps

module led_ripple_fade_pulse_effect_test;

  localparam int PAD_ROWS  = 4;
  localparam int FIRST_COL = 1;
  localparam int LAST_COL  = 6;
  localparam int LATENCY   = 18;
  localparam int N_RANDOM  = 950;

  typedef struct packed {
    logic [11:0] blue;
    logic [11:0] green;
    logic [11:0] red;
  } rgb_t;

  typedef struct {
    logic [1:0]  effect;
    logic [2:0]  row;
    logic [2:0]  col;
    logic        underglow;
    logic [15:0] elapsed;
    logic        typed;
    rgb_t        level;
  } pixel_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  // Predictor copy of the registers.
  logic [15:0] ripple_dur, fade_dur, rise_ms, hold_ms, fall_ms, max_rad;
  logic [11:0] steady;

  rgb_t pending_levels[$];
  int   errors = 0;
  bit   long_hold = 1'b0;

  always #5 clk = ~clk;

  led_ripple_fade_pulse_effect uut (.*);

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic rgb_t led_level(logic [1:0] effect, logic [2:0] row, logic [2:0] col,
                                     logic underglow, logic [15:0] e);
    rgb_t res;
    longint radius, dr2, dc2, dist_q, edge_q;
    longint t, a, v, lv;
    res = '0;
    lv = 0;
    if (effect == lrf_pkg::EFF_RIPPLE && !underglow) begin
      if (ripple_dur == 0) radius = max_rad;
      else begin
        t = (e < ripple_dur) ? e : ripple_dur;
        radius = t * max_rad / ripple_dur;
      end
      dr2 = 2 * longint'(row) - 2 * PAD_ROWS;
      dc2 = 2 * longint'(col) - (FIRST_COL + LAST_COL);
      dist_q = root_floor((dr2 * dr2 + dc2 * dc2) <<< 22);
      edge_q = radius - dist_q;
      if (edge_q < 0) edge_q = 0;
      if (edge_q > 4096) edge_q = 4096;
      lv = edge_q * steady / 4096;
      res = '{lv[11:0], lv[11:0], lv[11:0]};
    end else if (effect == lrf_pkg::EFF_FADE && !underglow) begin
      if (fade_dur != 0) begin
        t = (e < fade_dur) ? e : fade_dur;
        lv = longint'(steady) * (fade_dur - t) / fade_dur;
      end
      res = '{lv[11:0], lv[11:0], lv[11:0]};
    end else if (effect == lrf_pkg::EFF_PULSE) begin
      if (e < rise_ms) lv = longint'(e) * 4096 / rise_ms;
      else begin
        a = e - rise_ms;
        if (a < hold_ms) lv = 4095;
        else begin
          a = a - hold_ms;
          if (a < fall_ms) begin
            v = (fall_ms - a) * 4096 / fall_ms;
            lv = (v > 4095) ? 4095 : v;
          end
        end
      end
      res.red = lv[11:0];
      res.blue = lv[11:0];
      res.green = (!underglow && row == 0) ? lv[11:0] : '0;
    end
    return res;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lrf_pkg::REG_RIPPLE_DUR: ripple_dur = val;
      lrf_pkg::REG_FADE_DUR:   fade_dur = val;
      lrf_pkg::REG_RISE:       rise_ms = val;
      lrf_pkg::REG_HOLD:       hold_ms = val;
      lrf_pkg::REG_FALL:       fall_ms = val;
      lrf_pkg::REG_STEADY:     steady = val[11:0];
      default:                 max_rad = val;
    endcase
  endtask

  // Offer one word; hold it until accepted. Prediction is queued at acceptance.
  task automatic send_pixel(pixel_row_t p);
    rgb_t lv;
    lv = led_level(p.effect, p.row, p.col, p.underglow, p.elapsed);
    if (p.typed && lv != p.level)
      $display("%0t predictor disagrees with table: expected %h actual %h",
               $time, p.level, lv);
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, p.elapsed, p.col, p.row};
    in_tuser <= {p.underglow, p.effect};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_levels.push_back(p.typed ? p.level : lv);
  endtask

  task automatic idle_input(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (pending_levels.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic pixel_row_t rand_pixel();
    pixel_row_t p;
    p.effect = $urandom_range(0, 9) == 0 ? lrf_pkg::EFF_NONE : 2'($urandom_range(0, 2));
    p.row = $urandom_range(0, 15) == 0 ? 3'($urandom) : 3'($urandom_range(0, 4));
    p.col = $urandom_range(0, 15) == 0 ? 3'($urandom) : 3'($urandom_range(1, 6));
    p.underglow = $urandom_range(0, 4) == 0;
    case ($urandom_range(0, 3))
      0: p.elapsed = 16'($urandom);
      1: p.elapsed = 16'($urandom_range(0, 1500));
      default: p.elapsed = 16'($urandom_range(0, 700));
    endcase
    p.typed = 1'b0;
    p.level = '0;
    return p;
  endfunction

  // Receiver: random stall pattern, plus long hold-offs while long_hold is set.
  initial begin
    int k;
    k = 0;
    forever begin
      @(posedge clk);
      k++;
      if (long_hold) out_tready <= 1'b0;
      else if ((k / 64) % 3 == 0) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Output checker.
  always @(posedge clk) begin
    rgb_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[35:0];
      if (pending_levels.size() == 0) begin
        $display("%0t unexpected word: expected none actual %h", $time, got);
        errors++;
      end else begin
        want = pending_levels.pop_front();
        if (got.red != want.red)
          $display("%0t red: expected %h actual %h", $time, want.red, got.red);
        if (got.green != want.green)
          $display("%0t green: expected %h actual %h", $time, want.green, got.green);
        if (got.blue != want.blue)
          $display("%0t blue: expected %h actual %h", $time, want.blue, got.blue);
        if (got != want) errors++;
      end
    end
  end

  initial begin
    #50ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    pixel_row_t directed[$];
    pixel_row_t p;
    int n;
    ripple_dur = 900; fade_dur = 500; rise_ms = 150; hold_ms = 120; fall_ms = 350;
    steady = 3686; max_rad = 18842;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: typed levels only where obvious.
    directed = '{
      '{lrf_pkg::EFF_RIPPLE, 3'd4, 3'd3, 1'b0, 16'd0,     1'b0, '0},
      '{lrf_pkg::EFF_RIPPLE, 3'd4, 3'd3, 1'b0, 16'd65535, 1'b0, '0},
      '{lrf_pkg::EFF_RIPPLE, 3'd0, 3'd1, 1'b0, 16'd450,   1'b0, '0},
      '{lrf_pkg::EFF_RIPPLE, 3'd7, 3'd7, 1'b0, 16'd900,   1'b0, '0},
      '{lrf_pkg::EFF_RIPPLE, 3'd2, 3'd0, 1'b1, 16'd900,   1'b1, '0},
      '{lrf_pkg::EFF_FADE,   3'd1, 3'd2, 1'b0, 16'd0,     1'b1,
        '{12'd3686, 12'd3686, 12'd3686}},
      '{lrf_pkg::EFF_FADE,   3'd1, 3'd2, 1'b0, 16'd65535, 1'b1, '0},
      '{lrf_pkg::EFF_FADE,   3'd3, 3'd6, 1'b0, 16'd250,   1'b0, '0},
      '{lrf_pkg::EFF_FADE,   3'd0, 3'd4, 1'b1, 16'd0,     1'b1, '0},
      '{lrf_pkg::EFF_PULSE,  3'd0, 3'd1, 1'b0, 16'd0,     1'b1, '0},
      '{lrf_pkg::EFF_PULSE,  3'd0, 3'd1, 1'b0, 16'd200,   1'b1,
        '{12'hFFF, 12'hFFF, 12'hFFF}},
      '{lrf_pkg::EFF_PULSE,  3'd2, 3'd5, 1'b0, 16'd200,   1'b1,
        '{12'hFFF, 12'd0, 12'hFFF}},
      '{lrf_pkg::EFF_PULSE,  3'd0, 3'd5, 1'b1, 16'd150,   1'b1,
        '{12'hFFF, 12'd0, 12'hFFF}},
      '{lrf_pkg::EFF_PULSE,  3'd1, 3'd3, 1'b0, 16'd75,    1'b0, '0},
      '{lrf_pkg::EFF_PULSE,  3'd1, 3'd3, 1'b0, 16'd270,   1'b0, '0},
      '{lrf_pkg::EFF_PULSE,  3'd1, 3'd3, 1'b0, 16'd400,   1'b0, '0},
      '{lrf_pkg::EFF_PULSE,  3'd1, 3'd3, 1'b0, 16'd65535, 1'b1, '0},
      '{lrf_pkg::EFF_NONE,   3'd0, 3'd1, 1'b0, 16'd100,   1'b1, '0},
      '{lrf_pkg::EFF_NONE,   3'd7, 3'd7, 1'b1, 16'hFFFF,  1'b1, '0}
    };
    foreach (directed[i]) send_pixel(directed[i]);
    drain();

    // Zero-duration and extreme settings, then more directed rows.
    write_reg(lrf_pkg::REG_RIPPLE_DUR, 16'd0);
    write_reg(lrf_pkg::REG_FADE_DUR, 16'd0);
    write_reg(lrf_pkg::REG_RISE, 16'd0);
    write_reg(lrf_pkg::REG_HOLD, 16'd0);
    write_reg(lrf_pkg::REG_FALL, 16'd0);
    write_reg(lrf_pkg::REG_STEADY, 16'hFFFF);
    write_reg(lrf_pkg::REG_MAX_RADIUS, 16'hFFFF);
    p = '{lrf_pkg::EFF_FADE, 3'd1, 3'd1, 1'b0, 16'd5, 1'b1, '0};
    send_pixel(p);
    p = '{lrf_pkg::EFF_PULSE, 3'd0, 3'd1, 1'b0, 16'd0, 1'b1, '0};
    send_pixel(p);
    p = '{lrf_pkg::EFF_RIPPLE, 3'd4, 3'd3, 1'b0, 16'd0, 1'b0, '0};
    send_pixel(p);
    drain();

    // Random phases over several settings.
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 1) begin
        write_reg(lrf_pkg::REG_RIPPLE_DUR, 16'd1);
        write_reg(lrf_pkg::REG_FADE_DUR, 16'hFFFF);
        write_reg(lrf_pkg::REG_RISE, 16'd1);
        write_reg(lrf_pkg::REG_HOLD, 16'hFFFF);
        write_reg(lrf_pkg::REG_FALL, 16'd1);
        write_reg(lrf_pkg::REG_STEADY, 16'd0);
        write_reg(lrf_pkg::REG_MAX_RADIUS, 16'd0);
      end else if (phase > 1) begin
        write_reg(lrf_pkg::REG_RIPPLE_DUR, 16'($urandom_range(1, 2000)));
        write_reg(lrf_pkg::REG_FADE_DUR, 16'($urandom_range(1, 2000)));
        write_reg(lrf_pkg::REG_RISE, 16'($urandom_range(0, 500)));
        write_reg(lrf_pkg::REG_HOLD, 16'($urandom_range(0, 500)));
        write_reg(lrf_pkg::REG_FALL, 16'($urandom_range(0, 500)));
        write_reg(lrf_pkg::REG_STEADY, 16'($urandom));
        write_reg(lrf_pkg::REG_MAX_RADIUS, 16'($urandom));
      end else begin
        write_reg(lrf_pkg::REG_RIPPLE_DUR, 16'd900);
        write_reg(lrf_pkg::REG_FADE_DUR, 16'd500);
        write_reg(lrf_pkg::REG_RISE, 16'd150);
        write_reg(lrf_pkg::REG_HOLD, 16'd120);
        write_reg(lrf_pkg::REG_FALL, 16'd350);
        write_reg(lrf_pkg::REG_STEADY, 16'd3686);
        write_reg(lrf_pkg::REG_MAX_RADIUS, 16'd18842);
      end
      n = 0;
      while (n < N_RANDOM / 5) begin
        // A burst of words, then sometimes a gap.
        repeat ($urandom_range(1, 30)) begin
          if (n < N_RANDOM / 5) begin
            send_pixel(rand_pixel());
            n++;
          end
        end
        if (phase == 2 && n > 60 && !long_hold && n < 100) begin
          long_hold = 1'b1;
          fork
            begin
              repeat (200) @(posedge clk);
              long_hold = 1'b0;
            end
          join_none
        end
        if ($urandom_range(0, 1)) idle_input($urandom_range(1, 12));
      end
      // Sender waits for every word to come back before the next phase.
      drain();
    end

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
